@@ rtl/ghal_pkg.sv @@
`timescale 1ns / 1ps

package ghal_pkg;

    // Default table size and version width.
    localparam int SLOTS_DEFAULT        = 256;
    localparam int VERSION_BITS_DEFAULT = 8;

    // Fixed field widths on the stream ports.
    localparam int OP_W       = 2;
    localparam int NUM_W      = 8;
    localparam int VER_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 9;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;
    localparam int M_PAD_W    = M_DATA_W - NUM_W - VER_W - LIVE_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_HANDLE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One result as handed from the sequencer to the output stage.
    typedef struct packed {
        logic [LIVE_W-1:0] live_count;
        logic [VER_W-1:0]  new_version;
        logic [NUM_W-1:0]  new_number;
        status_t           status;
    } resp_t;

endpackage

@@ rtl/ghal_ram.sv @@
`timescale 1ns / 1ps

module ghal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with a registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ghal_resp.sv @@
`timescale 1ns / 1ps

module ghal_resp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ghal_pkg::resp_t                in_resp,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_number [7:0], new_version [15:8], live_count [24:16], zeros above
    output logic [ghal_pkg::M_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [ghal_pkg::STATUS_W-1:0]  m_tuser
);

    logic            valid_reg;
    ghal_pkg::resp_t data_reg;

    // The register takes a new result when empty or when its result leaves.
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= in_resp;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{ghal_pkg::M_PAD_W{1'b0}}, data_reg.live_count,
                       data_reg.new_version, data_reg.new_number};
    assign m_tuser  = data_reg.status;

endmodule

@@ rtl/ghal_ctrl.sv @@
`timescale 1ns / 1ps

module ghal_ctrl #(
    parameter int SLOTS        = ghal_pkg::SLOTS_DEFAULT,
    parameter int VERSION_BITS = ghal_pkg::VERSION_BITS_DEFAULT,
    localparam int IDX_W       = $clog2(SLOTS),
    localparam int CNT_W       = $clog2(SLOTS + 1),
    localparam int H_W         = IDX_W + VERSION_BITS,
    localparam int SP_W        = IDX_W + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input transactions.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ghal_pkg::OP_W-1:0]     in_op,
    input  logic [ghal_pkg::NUM_W-1:0]    in_number,
    input  logic [ghal_pkg::VER_W-1:0]    in_version,
    // Result towards the output stage.
    output logic                          res_valid,
    input  logic                          res_ready,
    output ghal_pkg::resp_t               res,
    // Slot table: valid bit over dense position.
    output logic                          slot_we,
    output logic [IDX_W-1:0]              slot_waddr,
    output logic [SP_W-1:0]               slot_wdata,
    output logic [IDX_W-1:0]              slot_raddr,
    input  logic [SP_W-1:0]               slot_rdata,
    // Dense array of live handles: number over version.
    output logic                          dense_we,
    output logic [IDX_W-1:0]              dense_waddr,
    output logic [H_W-1:0]                dense_wdata,
    output logic [IDX_W-1:0]              dense_raddr,
    input  logic [H_W-1:0]                dense_rdata,
    // Free stack: number over bumped version.
    output logic                          free_we,
    output logic [IDX_W-1:0]              free_waddr,
    output logic [H_W-1:0]                free_wdata,
    output logic [IDX_W-1:0]              free_raddr,
    input  logic [H_W-1:0]                free_rdata
);

    localparam int NC_W  = (CNT_W > ghal_pkg::NUM_W) ? CNT_W : ghal_pkg::NUM_W;
    localparam int VC_W  = (VERSION_BITS > ghal_pkg::VER_W) ? VERSION_BITS
                                                            : ghal_pkg::VER_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_C_POP,
        S_C_WR,
        S_D_SLOT,
        S_D_VER,
        S_D_LAST,
        S_D_FIN,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        free_top_reg, free_top_next;
    logic [CNT_W-1:0]        dense_count_reg, dense_count_next;
    logic [CNT_W-1:0]        slots_used_reg, slots_used_next;
    logic [IDX_W-1:0]        num_reg, num_next;
    logic [ghal_pkg::VER_W-1:0] ver_reg, ver_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        h_num_reg, h_num_next;
    logic [VERSION_BITS-1:0] h_ver_reg, h_ver_next;
    ghal_pkg::resp_t         resp_reg, resp_next;

    logic                    accept;
    logic                    slot_valid;
    logic [IDX_W-1:0]        slot_pos;
    logic [IDX_W-1:0]        last_num;
    logic [VERSION_BITS-1:0] stored_ver;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign res_valid  = (state_reg == S_RESP);
    assign res        = resp_reg;

    assign slot_valid = slot_rdata[IDX_W];
    assign slot_pos   = slot_rdata[IDX_W-1:0];
    assign last_num   = dense_rdata[H_W-1:VERSION_BITS];
    assign stored_ver = dense_rdata[VERSION_BITS-1:0];

    // Sequencer: next state, counters and memory accesses.
    always_comb begin
        state_next       = state_reg;
        free_top_next    = free_top_reg;
        dense_count_next = dense_count_reg;
        slots_used_next  = slots_used_reg;
        num_next         = num_reg;
        ver_next         = ver_reg;
        pos_next         = pos_reg;
        h_num_next       = h_num_reg;
        h_ver_next       = h_ver_reg;
        resp_next        = resp_reg;

        slot_we     = 1'b0;
        slot_waddr  = '0;
        slot_wdata  = '0;
        slot_raddr  = IDX_W'(in_number);
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        dense_raddr = '0;
        free_we     = 1'b0;
        free_waddr  = '0;
        free_wdata  = '0;
        free_raddr  = IDX_W'(free_top_reg - 1'b1);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    resp_next.status      = ghal_pkg::ST_OK;
                    resp_next.new_number  = '0;
                    resp_next.new_version = '0;
                    resp_next.live_count  = ghal_pkg::LIVE_W'(dense_count_reg);
                    state_next            = S_RESP;
                    case (in_op)
                        ghal_pkg::OP_CREATE: begin
                            if (dense_count_reg == FULL_COUNT) begin
                                resp_next.status = ghal_pkg::ST_FULL;
                            end else if (free_top_reg != '0) begin
                                // Pop the newest freed handle; data arrives next cycle.
                                free_top_next = free_top_reg - 1'b1;
                                state_next    = S_C_POP;
                            end else if (slots_used_reg != FULL_COUNT) begin
                                h_num_next      = IDX_W'(slots_used_reg);
                                h_ver_next      = '0;
                                slots_used_next = slots_used_reg + 1'b1;
                                state_next      = S_C_WR;
                            end else begin
                                resp_next.status = ghal_pkg::ST_FULL;
                            end
                        end
                        ghal_pkg::OP_DESTROY: begin
                            // Slot numbers never handed out do not exist.
                            if (NC_W'(in_number) >= NC_W'(slots_used_reg)) begin
                                resp_next.status = ghal_pkg::ST_NO_HANDLE;
                            end else begin
                                num_next   = IDX_W'(in_number);
                                ver_next   = in_version;
                                state_next = S_D_SLOT;
                            end
                        end
                        ghal_pkg::OP_CLEAR: begin
                            free_top_next        = '0;
                            dense_count_next     = '0;
                            slots_used_next      = '0;
                            resp_next.live_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_C_POP: begin
                h_num_next = free_rdata[H_W-1:VERSION_BITS];
                h_ver_next = free_rdata[VERSION_BITS-1:0];
                state_next = S_C_WR;
            end
            S_C_WR: begin
                // Append the handle and record its dense position.
                dense_we              = 1'b1;
                dense_waddr           = IDX_W'(dense_count_reg);
                dense_wdata           = {h_num_reg, h_ver_reg};
                slot_we               = 1'b1;
                slot_waddr            = h_num_reg;
                slot_wdata            = {1'b1, IDX_W'(dense_count_reg)};
                dense_count_next      = dense_count_reg + 1'b1;
                resp_next.status      = ghal_pkg::ST_OK;
                resp_next.new_number  = ghal_pkg::NUM_W'(h_num_reg);
                resp_next.new_version = ghal_pkg::VER_W'(h_ver_reg);
                resp_next.live_count  = ghal_pkg::LIVE_W'(dense_count_reg + 1'b1);
                state_next            = S_RESP;
            end
            S_D_SLOT: begin
                if (!slot_valid || (CNT_W'(slot_pos) >= dense_count_reg)) begin
                    resp_next.status = ghal_pkg::ST_NO_HANDLE;
                    state_next       = S_RESP;
                end else begin
                    pos_next    = slot_pos;
                    dense_raddr = slot_pos;
                    state_next  = S_D_VER;
                end
            end
            S_D_VER: begin
                // The version is compared unmasked against the stored one.
                if (VC_W'(stored_ver) != VC_W'(ver_reg)) begin
                    resp_next.status = ghal_pkg::ST_NO_HANDLE;
                    state_next       = S_RESP;
                end else begin
                    dense_raddr = IDX_W'(dense_count_reg - 1'b1);
                    state_next  = S_D_LAST;
                end
            end
            S_D_LAST: begin
                // Move the last entry into the hole and repoint its slot.
                dense_we    = 1'b1;
                dense_waddr = pos_reg;
                dense_wdata = dense_rdata;
                slot_we     = 1'b1;
                slot_waddr  = last_num;
                slot_wdata  = {1'b1, pos_reg};
                if (free_top_reg != FULL_COUNT) begin
                    free_we       = 1'b1;
                    free_waddr    = IDX_W'(free_top_reg);
                    free_wdata    = {num_reg,
                                     VERSION_BITS'({1'b0, ver_reg} + 1'b1)};
                    free_top_next = free_top_reg + 1'b1;
                end
                state_next = S_D_FIN;
            end
            S_D_FIN: begin
                // Invalidate the destroyed slot after the repoint, so that a
                // handle which was itself the last entry ends up invalid.
                slot_we              = 1'b1;
                slot_waddr           = num_reg;
                slot_wdata           = '0;
                dense_count_next     = dense_count_reg - 1'b1;
                resp_next.status     = ghal_pkg::ST_OK;
                resp_next.live_count = ghal_pkg::LIVE_W'(dense_count_reg - 1'b1);
                state_next           = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and the pending result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            free_top_reg    <= '0;
            dense_count_reg <= '0;
            slots_used_reg  <= '0;
        end else begin
            state_reg       <= state_next;
            free_top_reg    <= free_top_next;
            dense_count_reg <= dense_count_next;
            slots_used_reg  <= slots_used_next;
        end
        num_reg   <= num_next;
        ver_reg   <= ver_next;
        pos_reg   <= pos_next;
        h_num_reg <= h_num_next;
        h_ver_reg <= h_ver_next;
        resp_reg  <= resp_next;
    end

endmodule

@@ rtl/generational_handle_allocator_core.sv @@
`timescale 1ns / 1ps

// Generational handle allocator: a slot map that hands out handles made of a
// slot number and a version. The operation travels on s_tuser (0 create,
// 1 destroy, 2 clear all) and every input transaction yields exactly one result
// transaction with a status on m_tuser (0 ok, 1 handle does not exist, 2 table
// full). Items are handled one at a time by a sequencer over three memories,
// each with one write port and one registered read port (slot table, dense
// array, free stack). A clear or a full-table create goes straight to the result;
// other creates write the entry, first popping the free stack if they reuse a
// freed handle; a successful destroy reads the slot table, checks the version,
// moves the last entry and invalidates the slot; a rejected destroy stops at
// the range, slot or version check. The next item is accepted once the sequencer
// is idle again after handing over the previous result; a result waiting at
// the output does not hold up the next item. There is no clearing pass after
// reset or clear: only the counters reset, and entries are never read unwritten.
module generational_handle_allocator_core #(
    parameter int SLOTS        = ghal_pkg::SLOTS_DEFAULT,
    parameter int VERSION_BITS = ghal_pkg::VERSION_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // handle_number [7:0], handle_version [15:8]
    input  logic [ghal_pkg::S_DATA_W-1:0]  s_tdata,
    // operation [1:0]
    input  logic [ghal_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_number [7:0], new_version [15:8], live_count [24:16], zeros above
    output logic [ghal_pkg::M_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [ghal_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int H_W   = IDX_W + VERSION_BITS;
    localparam int SP_W  = IDX_W + 1;

    logic              res_valid;
    logic              res_ready;
    ghal_pkg::resp_t   res;

    logic              slot_we;
    logic [IDX_W-1:0]  slot_waddr;
    logic [SP_W-1:0]   slot_wdata;
    logic [IDX_W-1:0]  slot_raddr;
    logic [SP_W-1:0]   slot_rdata;
    logic              dense_we;
    logic [IDX_W-1:0]  dense_waddr;
    logic [H_W-1:0]    dense_wdata;
    logic [IDX_W-1:0]  dense_raddr;
    logic [H_W-1:0]    dense_rdata;
    logic              free_we;
    logic [IDX_W-1:0]  free_waddr;
    logic [H_W-1:0]    free_wdata;
    logic [IDX_W-1:0]  free_raddr;
    logic [H_W-1:0]    free_rdata;

    // Operation sequencer and counters.
    ghal_ctrl #(
        .SLOTS        (SLOTS),
        .VERSION_BITS (VERSION_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_number   (s_tdata[ghal_pkg::NUM_W-1:0]),
        .in_version  (s_tdata[ghal_pkg::NUM_W +: ghal_pkg::VER_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .slot_we     (slot_we),
        .slot_waddr  (slot_waddr),
        .slot_wdata  (slot_wdata),
        .slot_raddr  (slot_raddr),
        .slot_rdata  (slot_rdata),
        .dense_we    (dense_we),
        .dense_waddr (dense_waddr),
        .dense_wdata (dense_wdata),
        .dense_raddr (dense_raddr),
        .dense_rdata (dense_rdata),
        .free_we     (free_we),
        .free_waddr  (free_waddr),
        .free_wdata  (free_wdata),
        .free_raddr  (free_raddr),
        .free_rdata  (free_rdata)
    );

    // Slot table.
    ghal_ram #(
        .WIDTH (SP_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Dense array of live handles.
    ghal_ram #(
        .WIDTH (H_W),
        .DEPTH (SLOTS)
    ) u_dense_ram (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    // Free stack.
    ghal_ram #(
        .WIDTH (H_W),
        .DEPTH (SLOTS)
    ) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    // Output register for result transactions.
    ghal_resp u_resp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_resp  (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
